FILE: hdl/cudf_pkg.sv
package cudf_pkg;

  // Frame layout
  localparam int unsigned HdrLen     = 10;
  localparam int unsigned MaxDataMax = 8;
  localparam int unsigned PosW       = 5;
  localparam logic [PosW-1:0] PosMax = '1;

  localparam logic [15:0] FrameMagic = 16'h2934;
  localparam logic [15:0] CrcPoly    = 16'h1021;
  localparam logic [15:0] CrcInit    = 16'hFFFF;

  // Byte offsets inside the header
  localparam logic [PosW-1:0] PosMagicLo = PosW'(0);
  localparam logic [PosW-1:0] PosMagicHi = PosW'(1);
  localparam logic [PosW-1:0] PosCrcLo   = PosW'(2);
  localparam logic [PosW-1:0] PosCrcHi   = PosW'(3);
  localparam logic [PosW-1:0] PosCrcFrom = PosW'(4);
  localparam logic [PosW-1:0] PosIdFrom  = PosW'(6);
  localparam logic [PosW-1:0] PosHdrEnd  = PosW'(HdrLen);

  typedef enum logic [1:0] {
    ST_GOOD    = 2'd0,
    ST_BAD_HDR = 2'd1,
    ST_BAD_CRC = 2'd2,
    ST_TOO_LONG = 2'd3
  } status_e;

  // One byte beat held in the input register
  typedef struct packed {
    logic       is_last;
    logic [7:0] data;
  } beat_t;

  // CRC-16-CCITT over one byte, MSB first
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                           input logic [7:0]  b);
    logic [15:0] c;
    c = crc_in ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

FILE: hdl/cudf_intf.sv
// Byte stream channel
interface cudf_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       is_last;

  modport source (output valid, output rx_byte, output is_last, input ready);
  modport sink   (input valid, input rx_byte, input is_last, output ready);
endinterface

// Frame result channel
interface cudf_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  frame_status;
  logic [31:0] msg_id;
  logic [3:0]  data_length;
  logic [63:0] frame_data;
  logic [31:0] good_frames;
  logic [31:0] bad_frames;

  modport source (output valid, output frame_status, output msg_id,
                  output data_length, output frame_data, output good_frames,
                  output bad_frames, input ready);
  modport sink   (input valid, input frame_status, input msg_id,
                  input data_length, input frame_data, input good_frames,
                  input bad_frames, output ready);
endinterface

FILE: hdl/cudf_in_reg.sv
module cudf_in_reg (
  input  logic            clk_i,
  input  logic            rst_ni,
  cudf_byte_if.sink       rx_i,
  input  logic            take_i,
  output logic            valid_o,
  output cudf_pkg::beat_t beat_o
);

  logic            valid_q;
  logic            valid_d;
  cudf_pkg::beat_t beat_q;

  // Take a new beat whenever the register is empty or drains this cycle
  assign rx_i.ready = !valid_q || take_i;

  always_comb begin
    valid_d = valid_q;
    if (rx_i.ready) begin
      valid_d = rx_i.valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload holds until the next accepted beat
  always_ff @(posedge clk_i) begin
    if (rx_i.ready && rx_i.valid) begin
      beat_q.data    <= rx_i.rx_byte;
      beat_q.is_last <= rx_i.is_last;
    end
  end

  assign valid_o = valid_q;
  assign beat_o  = beat_q;

endmodule

FILE: hdl/cudf_core.sv
module cudf_core #(
  parameter int unsigned MAX_DATA = cudf_pkg::MaxDataMax
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  cudf_pkg::beat_t beat_i,
  output logic            take_o,
  cudf_res_if.source      res_o
);

  localparam int unsigned PosW = cudf_pkg::PosW;
  localparam logic [PosW-1:0] PosDataEnd = PosW'(cudf_pkg::HdrLen + MAX_DATA);

  logic [PosW-1:0] pos_q,   pos_d;
  logic [15:0]     crc_q,   crc_d;
  logic [15:0]     magic_q, magic_d;
  logic [15:0]     hcrc_q,  hcrc_d;
  logic [31:0]     id_q,    id_d;
  logic [63:0]     data_q,  data_d;
  logic [31:0]     good_q,  good_d;
  logic [31:0]     bad_q,   bad_d;

  logic            res_valid_q, res_valid_d;
  logic            res_load;
  cudf_pkg::status_e status;
  logic [PosW-1:0] count;
  logic [1:0]      id_idx;
  logic [2:0]      data_idx;
  logic [PosW-1:0] id_off;
  logic [PosW-1:0] data_off;
  logic [PosW-1:0] dlen;

  // Drain the input register unless a final beat finds the result slot full
  assign take_o   = valid_i && (!beat_i.is_last || !res_valid_q || res_o.ready);
  assign res_load = take_o && beat_i.is_last;

  assign id_off   = pos_q - cudf_pkg::PosIdFrom;
  assign data_off = pos_q - cudf_pkg::PosHdrEnd;
  assign id_idx   = id_off[1:0];
  assign data_idx = data_off[2:0];
  assign count    = (pos_q != cudf_pkg::PosMax) ? pos_q + PosW'(1) : pos_q;
  assign dlen     = count - cudf_pkg::PosHdrEnd;

  // Capture header and data bytes, advance CRC, judge the frame on its last beat
  always_comb begin
    pos_d   = pos_q;
    crc_d   = crc_q;
    magic_d = magic_q;
    hcrc_d  = hcrc_q;
    id_d    = id_q;
    data_d  = data_q;
    good_d  = good_q;
    bad_d   = bad_q;
    status  = cudf_pkg::ST_GOOD;

    if (take_o) begin
      if (pos_q == cudf_pkg::PosMagicLo) begin
        magic_d[7:0] = beat_i.data;
      end else if (pos_q == cudf_pkg::PosMagicHi) begin
        magic_d[15:8] = beat_i.data;
      end else if (pos_q == cudf_pkg::PosCrcLo) begin
        hcrc_d[7:0] = beat_i.data;
      end else if (pos_q == cudf_pkg::PosCrcHi) begin
        hcrc_d[15:8] = beat_i.data;
      end else if (pos_q >= cudf_pkg::PosIdFrom && pos_q < cudf_pkg::PosHdrEnd) begin
        id_d[8*id_idx +: 8] = beat_i.data;
      end else if (pos_q >= cudf_pkg::PosHdrEnd && pos_q < PosDataEnd) begin
        data_d[8*data_idx +: 8] = beat_i.data;
      end

      if (pos_q >= cudf_pkg::PosCrcFrom) begin
        crc_d = cudf_pkg::crc_byte(crc_q, beat_i.data);
      end
      pos_d = count;

      if (count < cudf_pkg::PosHdrEnd || magic_d != cudf_pkg::FrameMagic) begin
        status = cudf_pkg::ST_BAD_HDR;
      end else if (count > PosDataEnd) begin
        status = cudf_pkg::ST_TOO_LONG;
      end else if (crc_d != hcrc_d) begin
        status = cudf_pkg::ST_BAD_CRC;
      end

      if (beat_i.is_last) begin
        if (status == cudf_pkg::ST_GOOD) begin
          if (good_q != '1) begin
            good_d = good_q + 32'd1;
          end
        end else if (bad_q != '1) begin
          bad_d = bad_q + 32'd1;
        end
        // Drop the frame state for the next datagram
        pos_d   = '0;
        crc_d   = cudf_pkg::CrcInit;
        magic_d = '0;
        hcrc_d  = '0;
        id_d    = '0;
        data_d  = '0;
      end
    end
  end

  always_comb begin
    res_valid_d = res_valid_q;
    if (res_o.ready) begin
      res_valid_d = 1'b0;
    end
    if (res_load) begin
      res_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      crc_q       <= cudf_pkg::CrcInit;
      magic_q     <= '0;
      hcrc_q      <= '0;
      id_q        <= '0;
      data_q      <= '0;
      good_q      <= '0;
      bad_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      pos_q       <= pos_d;
      crc_q       <= crc_d;
      magic_q     <= magic_d;
      hcrc_q      <= hcrc_d;
      id_q        <= id_d;
      data_q      <= data_d;
      good_q      <= good_d;
      bad_q       <= bad_d;
      res_valid_q <= res_valid_d;
    end
  end

  // Result register; error frames carry only the status and the counters
  always_ff @(posedge clk_i) begin
    if (res_load) begin
      res_o.frame_status <= status;
      res_o.good_frames  <= good_d;
      res_o.bad_frames   <= bad_d;
      if (status == cudf_pkg::ST_GOOD) begin
        // Merge the final beat, which may still be an id byte
        res_o.msg_id      <= id_q | ((pos_q >= cudf_pkg::PosIdFrom
                             && pos_q < cudf_pkg::PosHdrEnd)
                             ? (32'(beat_i.data) << (8*id_idx)) : 32'd0);
        res_o.data_length <= dlen[3:0];
        res_o.frame_data  <= data_q | ((beat_i.is_last && pos_q >= cudf_pkg::PosHdrEnd
                             && pos_q < PosDataEnd)
                             ? (64'(beat_i.data) << (8*data_idx)) : 64'd0);
      end else begin
        res_o.msg_id      <= '0;
        res_o.data_length <= '0;
        res_o.frame_data  <= '0;
      end
    end
  end

  assign res_o.valid = res_valid_q;

endmodule

FILE: hdl/can_udp_frame_deframer.sv
// Path: a result reaches the output register after the final byte is accepted,
// via the input then the result register; the byte-wide CRC step is unrolled.
// Throughput: one byte per cycle; a last byte stalls while a result is still held.
// Reset: asynchronous, active low; clears framing state, CRC to 0xFFFF and both
// frame counters at once, with no clearing pass.
module can_udp_frame_deframer #(
  parameter int unsigned MAX_DATA = cudf_pkg::MaxDataMax
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  cudf_byte_if.sink  rx_i,
  cudf_res_if.source res_o
);

  logic            in_valid;
  logic            in_take;
  cudf_pkg::beat_t in_beat;

  // Input register
  cudf_in_reg u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .rx_i    (rx_i),
    .take_i  (in_take),
    .valid_o (in_valid),
    .beat_o  (in_beat)
  );

  // Framing, CRC check and result register
  cudf_core #(
    .MAX_DATA (MAX_DATA)
  ) u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid),
    .beat_i  (in_beat),
    .take_o  (in_take),
    .res_o   (res_o)
  );

endmodule
